### src/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

    localparam int unsigned MAX_PAGES  = 128;
    localparam int unsigned MAX_FRAMES = 16;
    localparam int unsigned NUM_BLOCKS = 64;
    localparam int unsigned PAGE_SIZE  = 4132;

    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned PAGE_W  = 8;
    localparam int unsigned PIDX_W  = $clog2(MAX_PAGES);
    localparam int unsigned NPG_W   = 8;
    localparam int unsigned NFR_W   = 5;
    localparam int unsigned POS_W   = $clog2(MAX_FRAMES);
    localparam int unsigned OCC_W   = $clog2(MAX_FRAMES + 1);
    localparam int unsigned BLK_W   = 6;
    localparam int unsigned EVP_W   = 7;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned CFG_IDX_W = 2;

    // page = addr / PAGE_SIZE via reciprocal, one correction step
    localparam int unsigned DIV_SHIFT = 26;
    localparam longint unsigned DIV_RECIP = (64'd1 << DIV_SHIFT) / PAGE_SIZE;
    localparam int unsigned RECIP_W = $clog2(DIV_RECIP + 1);
    localparam int unsigned PROD_W  = ADDR_W + RECIP_W;

    // block map scanned in groups
    localparam int unsigned GRP    = 8;
    localparam int unsigned NGRP   = (NUM_BLOCKS + GRP - 1) / GRP;
    localparam int unsigned GIDX_W = $clog2(GRP);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MAP  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        LST_NONE   = 2'd0,
        LST_MOVE   = 2'd1,
        LST_APPEND = 2'd2
    } lst_op_t;

    typedef struct packed {
        lst_op_t               op;
        logic [POS_W-1:0]      pos;
        logic [PIDX_W-1:0]     page;
    } lst_ctl_t;

    typedef struct packed {
        logic                  found;
        logic [POS_W-1:0]      pos;
        logic [PIDX_W-1:0]     oldest;
        logic [OCC_W-1:0]      occ;
    } lst_sts_t;

endpackage

`default_nettype wire

### src/lrupr_in_if.sv
`default_nettype none

interface lrupr_in_if;
    import lrupr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

### src/lrupr_out_if.sv
`default_nettype none

interface lrupr_out_if;
    import lrupr_pkg::*;

    logic              valid;
    logic              ready;
    logic              out_of_range;
    logic              hit;
    logic [PAGE_W-1:0] page_number;
    logic [BLK_W-1:0]  block;
    logic              evicted_valid;
    logic [EVP_W-1:0]  evicted_page;
    logic              no_free_block;
    logic [CNT_W-1:0]  fault_count;

    modport source (output valid, output out_of_range, output hit, output page_number,
                    output block, output evicted_valid, output evicted_page,
                    output no_free_block, output fault_count, input ready);
    modport sink   (input valid, input out_of_range, input hit, input page_number,
                    input block, input evicted_valid, input evicted_page,
                    input no_free_block, input fault_count, output ready);
endinterface

`default_nettype wire

### src/lru_page_replacement.sv
// LRU page replacement unit. Each transfer on req carries one byte address; the unit
// divides it by the page size, checks the page against num_pages and then either
// refreshes a resident page, fills a free frame from the lowest free block of the
// 64-block map, or evicts the least recent page and reuses its block. One address
// goes from transfer to result in four steps: the reciprocal multiply, the quotient
// correction with a grouped scan of the block map, one read of the page-to-block
// memory, and the update of the recency list, valid bits, map and fault counter.
// Those four steps run under a small sequencer, so req is ready only in the idle
// step. The result sits in an output register on rsp; the next address is taken
// while it waits, and the update step holds until that register is free.
// Configuration writes land in the cycle of the write; a block map write replaces
// the usage map at once.
`default_nettype none

module lru_page_replacement (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    lrupr_in_if.sink                             req,
    lrupr_out_if.source                          rsp,
    input  wire logic                            cfg_we,
    input  wire logic [lrupr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lrupr_pkg::CFG_W-1:0]     cfg_data
);
    import lrupr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [NPG_W-1:0]      num_pages_reg;
    logic [NFR_W-1:0]      num_frames_reg;
    logic [NUM_BLOCKS-1:0] block_used_reg;
    logic [NUM_BLOCKS-1:0] block_used_next;
    logic [MAX_PAGES-1:0]  page_valid_reg;
    logic [MAX_PAGES-1:0]  page_valid_next;
    logic [CNT_W-1:0]      faults_reg;
    logic [CNT_W-1:0]      faults_next;

    logic [PAGE_W-1:0]     div_page;
    logic [PAGE_W-1:0]     page_reg;
    logic [PIDX_W-1:0]     pidx;

    logic                  grp_any_reg [NGRP];
    logic [GIDX_W-1:0]     grp_idx_reg [NGRP];
    logic                  grp_any_c   [NGRP];
    logic [GIDX_W-1:0]     grp_idx_c   [NGRP];
    logic [BLK_W-1:0]      free_blk_reg;
    logic [BLK_W-1:0]      free_blk_c;
    logic                  nofree_reg;
    logic                  nofree_c;

    logic [BLK_W-1:0]      page_block_mem [MAX_PAGES];
    logic [PIDX_W-1:0]     rd_addr;
    logic [BLK_W-1:0]      rd_reg;

    lst_ctl_t              lst_ctl;
    lst_sts_t              lst_sts;

    logic                  accept;
    logic                  upd_go;
    logic                  oor;
    logic                  full;
    logic [OCC_W-1:0]      cap;
    logic                  mem_we;

    logic                  res_oor, res_hit, res_ev, res_nofree;
    logic [BLK_W-1:0]      res_blk;
    logic [EVP_W-1:0]      res_evp;

    logic                  out_valid_reg;
    logic                  out_oor_reg, out_hit_reg, out_ev_reg, out_nofree_reg;
    logic [PAGE_W-1:0]     out_page_reg;
    logic [BLK_W-1:0]      out_blk_reg;
    logic [EVP_W-1:0]      out_evp_reg;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign upd_go    = (state_reg == ST_UPD) && (!out_valid_reg || rsp.ready);
    assign pidx      = page_reg[PIDX_W-1:0];

    lrupr_div u_div (
        .clk     (clk),
        .start   (accept),
        .address (req.address),
        .page    (div_page)
    );

    lrupr_list u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (lst_ctl),
        .sts   (lst_sts)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV:  state_next = ST_LOOK;
            ST_LOOK: state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // first free block inside each group of the map
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_c[g] = 1'b0;
            grp_idx_c[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (g * GRP + b < NUM_BLOCKS && !block_used_reg[g * GRP + b])
                begin
                    grp_any_c[g] = 1'b1;
                    grp_idx_c[g] = GIDX_W'(b);
                end
            end
        end
    end

    // lowest group with a free block
    always_comb
    begin
        nofree_c   = 1'b1;
        free_blk_c = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                nofree_c   = 1'b0;
                free_blk_c = BLK_W'(g * GRP) | BLK_W'(grp_idx_reg[g]);
            end
        end
    end

    always_comb
    begin
        oor = ({1'b0, page_reg} >= (PAGE_W + 1)'(num_pages_reg))
              || ({1'b0, page_reg} >= (PAGE_W + 1)'(MAX_PAGES));
        if (num_frames_reg == '0)
            cap = OCC_W'(1);
        else if (int'(num_frames_reg) > MAX_FRAMES)
            cap = OCC_W'(MAX_FRAMES);
        else
            cap = OCC_W'(num_frames_reg);
        full    = lst_sts.occ >= cap;
        rd_addr = page_valid_reg[pidx] ? pidx : lst_sts.oldest;
    end

    always_comb
    begin
        res_oor         = 1'b0;
        res_hit         = 1'b0;
        res_ev          = 1'b0;
        res_evp         = '0;
        res_nofree      = 1'b0;
        res_blk         = '0;
        mem_we          = 1'b0;
        block_used_next = block_used_reg;
        page_valid_next = page_valid_reg;
        faults_next     = faults_reg;
        lst_ctl.op      = LST_NONE;
        lst_ctl.pos     = lst_sts.pos;
        lst_ctl.page    = pidx;

        if (oor)
        begin
            res_oor = 1'b1;
        end
        else if (page_valid_reg[pidx])
        begin
            res_hit = 1'b1;
            res_blk = rd_reg;
            if (lst_sts.found)
                lst_ctl.op = LST_MOVE;
        end
        else
        begin
            if (faults_reg != '1)
                faults_next = faults_reg + 1'b1;
            if (!full)
            begin
                res_nofree      = nofree_reg;
                res_blk         = nofree_reg ? '0 : free_blk_reg;
                block_used_next = block_used_reg | (NUM_BLOCKS'(1) << res_blk);
                lst_ctl.op      = LST_APPEND;
            end
            else
            begin
                res_ev  = 1'b1;
                res_evp = EVP_W'(lst_sts.oldest);
                res_blk = rd_reg;
                page_valid_next[lst_sts.oldest] = 1'b0;
                lst_ctl.op  = LST_MOVE;
                lst_ctl.pos = '0;
            end
            page_valid_next[pidx] = 1'b1;
            mem_we = 1'b1;
        end

        if (!upd_go)
        begin
            lst_ctl.op = LST_NONE;
            mem_we     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            page_block_mem[pidx] <= res_blk;
        if (state_reg == ST_LOOK)
            rd_reg <= page_block_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            page_reg <= div_page;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_any_reg[g] <= grp_any_c[g];
                grp_idx_reg[g] <= grp_idx_c[g];
            end
        end
        if (state_reg == ST_LOOK)
        begin
            free_blk_reg <= free_blk_c;
            nofree_reg   <= nofree_c;
        end
        if (upd_go)
        begin
            out_oor_reg    <= res_oor;
            out_hit_reg    <= res_hit;
            out_page_reg   <= page_reg;
            out_blk_reg    <= res_blk;
            out_ev_reg     <= res_ev;
            out_evp_reg    <= res_evp;
            out_nofree_reg <= res_nofree;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_pages_reg  <= NPG_W'(MAX_PAGES);
            num_frames_reg <= NFR_W'(4);
            block_used_reg <= '0;
            page_valid_reg <= '0;
            faults_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_NUM_PAGES)
                num_pages_reg <= NPG_W'(cfg_data);
            if (cfg_we && cfg_index == CFG_NUM_FRAMES)
                num_frames_reg <= NFR_W'(cfg_data);
            if (cfg_we && cfg_index == CFG_BLOCK_MAP)
                block_used_reg <= NUM_BLOCKS'(cfg_data);
            else if (upd_go)
                block_used_reg <= block_used_next;
            if (upd_go)
            begin
                page_valid_reg <= page_valid_next;
                faults_reg     <= faults_next;
            end
            if (upd_go)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_of_range  = out_oor_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.page_number   = out_page_reg;
    assign rsp.block         = out_blk_reg;
    assign rsp.evicted_valid = out_ev_reg;
    assign rsp.evicted_page  = out_evp_reg;
    assign rsp.no_free_block = out_nofree_reg;
    assign rsp.fault_count   = faults_reg;

endmodule

`default_nettype wire

### src/lrupr_div.sv
`default_nettype none

module lrupr_div (
    input  wire logic                         clk,
    input  wire logic                         start,
    input  wire logic [lrupr_pkg::ADDR_W-1:0] address,
    output logic      [lrupr_pkg::PAGE_W-1:0] page
);
    import lrupr_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PAGE_W-1:0] q0;
    logic [ADDR_W-1:0] rem;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(address) * PROD_W'(DIV_RECIP);
            addr_reg <= address;
        end
    end

    // estimate is exact or one low
    always_comb
    begin
        q0   = PAGE_W'(prod_reg >> DIV_SHIFT);
        rem  = addr_reg - ADDR_W'(q0 * PAGE_SIZE);
        page = q0 + PAGE_W'(rem >= ADDR_W'(PAGE_SIZE));
    end

endmodule

`default_nettype wire

### src/lrupr_list.sv
`default_nettype none

module lrupr_list (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lrupr_pkg::lst_ctl_t ctl,
    output lrupr_pkg::lst_sts_t      sts
);
    import lrupr_pkg::*;

    logic [PIDX_W-1:0] list_reg  [MAX_FRAMES];
    logic [PIDX_W-1:0] list_next [MAX_FRAMES];
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;

    // lowest matching slot among the occupied ones
    always_comb
    begin
        sts.found  = 1'b0;
        sts.pos    = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (OCC_W'(i) < occ_reg && list_reg[i] == ctl.page)
            begin
                sts.found = 1'b1;
                sts.pos   = POS_W'(i);
            end
        end
        sts.oldest = list_reg[0];
        sts.occ    = occ_reg;
    end

    // move: close the gap at pos and put the page at the newest end; append: add it after the newest
    always_comb
    begin
        occ_next = occ_reg;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            list_next[i] = list_reg[i];
            unique case (ctl.op)
                LST_MOVE:
                begin
                    if (OCC_W'(i) + 1'b1 == occ_reg)
                        list_next[i] = ctl.page;
                    else if (POS_W'(i) >= ctl.pos && OCC_W'(i) + 1'b1 < occ_reg)
                        list_next[i] = list_reg[(i + 1) % MAX_FRAMES];
                end
                LST_APPEND:
                begin
                    if (OCC_W'(i) == occ_reg)
                        list_next[i] = ctl.page;
                end
                default:
                begin
                end
            endcase
        end
        if (ctl.op == LST_APPEND)
            occ_next = occ_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
            list_reg[i] <= list_next[i];
    end

endmodule

`default_nettype wire

### src/lrupr_chk.sv
`default_nettype none

module lrupr_chk (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_ready,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic                        out_of_range,
    input  wire logic                        hit,
    input  wire logic                        evicted_valid,
    input  wire logic                        no_free_block,
    input  wire logic [lrupr_pkg::CNT_W-1:0] fault_count
);
    import lrupr_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one address at a time: busy right after a transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an input transfer");

    // eviction and block shortage only come with a fault
    a_fault_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit || out_of_range) |-> !evicted_valid && !no_free_block)
        else $error("eviction or block flag without a fault");

    // a fault result always carries a nonzero count
    a_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit && !out_of_range |-> fault_count != '0)
        else $error("fault reported with zero count");

endmodule

bind lru_page_replacement lrupr_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (req.valid),
    .in_ready      (req.ready),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_of_range  (rsp.out_of_range),
    .hit           (rsp.hit),
    .evicted_valid (rsp.evicted_valid),
    .no_free_block (rsp.no_free_block),
    .fault_count   (rsp.fault_count)
);

`default_nettype wire
